// ----- rtl/tss_pkg.sv -----
// shared types for the two-stack sorter: controller states, commands and status
package tss_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_MV_RD,
    ST_MV_WR,
    ST_AX_RD,
    ST_AX_LD,
    ST_CMP,
    ST_CMP_WT,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef struct packed {
    logic accept;   // input request taken
    logic mv_rd;    // read main top for the move to aux
    logic mv_wr;    // write read main top onto aux
    logic ax_rd;    // pop aux, read its top
    logic ax_ld;    // capture popped aux value as the held element
    logic cmp_rd;   // read main top for compare
    logic cmp_mv;   // move smaller main top back onto aux
    logic push_t;   // push held element onto main
    logic out_rd;   // pop main for output
    logic out_ld;   // load output register
    logic clear;    // end of run
  } cmd_t;

  typedef struct packed {
    logic main_empty;
    logic aux_empty;
    logic full;
    logic gt;       // held element > main top read data (signed)
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/tss_ram.sv -----
// generic single write port, single read port ram with registered read
module tss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tss_ctrl.sv -----
// sequencer for fill, two-stack insertion sort and ordered drain
module tss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  tss_pkg::sts_t sts,
  output tss_pkg::cmd_t cmd
);

  import tss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) state_nxt = ST_MV_RD;
        end
      end
      ST_MV_RD: begin
        if (sts.main_empty) begin
          state_nxt = ST_AX_RD;
        end else begin
          cmd.mv_rd = 1'b1;
          state_nxt = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = ST_MV_RD;
      end
      ST_AX_RD: begin
        if (sts.aux_empty) begin
          state_nxt = ST_OUT_RD;
        end else begin
          cmd.ax_rd = 1'b1;
          state_nxt = ST_AX_LD;
        end
      end
      ST_AX_LD: begin
        cmd.ax_ld = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.main_empty) begin
          cmd.push_t = 1'b1;
          state_nxt  = ST_AX_RD;
        end else begin
          cmd.cmp_rd = 1'b1;
          state_nxt  = ST_CMP_WT;
        end
      end
      ST_CMP_WT: begin
        // smaller main values go back to aux until the held one can sink
        if (sts.gt) begin
          cmd.cmp_mv = 1'b1;
          state_nxt  = ST_CMP;
        end else begin
          cmd.push_t = 1'b1;
          state_nxt  = ST_AX_RD;
        end
      end
      ST_OUT_RD: begin
        if (sts.main_empty) begin
          cmd.clear = 1'b1;
          state_nxt = ST_FILL;
        end else if (sts.out_free) begin
          cmd.out_rd = 1'b1;
          state_nxt  = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = ST_OUT_RD;
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

endmodule

// ----- rtl/tss_dp.sv -----
// datapath: main and aux stack rams, counts, held element and output register
module tss_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tss_pkg::cmd_t               cmd,
  output tss_pkg::sts_t               sts,
  input  logic [tss_pkg::DATA_W-1:0]  in_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [tss_pkg::DATA_W-1:0]  out_value_res,
  output logic                        out_last_res,
  output logic                        out_overflow
);

  import tss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     main_cnt_r, main_cnt_nxt, aux_cnt_r, aux_cnt_nxt;
  logic [CW-1:0]     main_dec, aux_dec;
  logic              ovf_r, ovf_nxt;
  logic [DATA_W-1:0] t_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r, out_ovf_r;

  logic              m_we, m_re, a_we, a_re;
  logic [AW-1:0]     m_wa, m_ra, a_wa, a_ra;
  logic [DATA_W-1:0] m_wd, m_rd, a_wd, a_rd;

  assign main_dec = main_cnt_r - CW'(1);
  assign aux_dec  = aux_cnt_r - CW'(1);

  tss_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_main (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd),
    .re(m_re), .raddr(m_ra), .rdata(m_rd)
  );

  tss_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_aux (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd),
    .re(a_re), .raddr(a_ra), .rdata(a_rd)
  );

  always_comb begin
    main_cnt_nxt = main_cnt_r;
    aux_cnt_nxt  = aux_cnt_r;
    ovf_nxt      = ovf_r;
    m_we = 1'b0;
    m_re = 1'b0;
    a_we = 1'b0;
    a_re = 1'b0;
    m_wa = main_cnt_r[AW-1:0];
    m_ra = main_dec[AW-1:0];
    a_wa = aux_cnt_r[AW-1:0];
    a_ra = aux_dec[AW-1:0];
    m_wd = t_r;
    a_wd = m_rd;
    if (cmd.accept) begin
      if (sts.full) begin
        ovf_nxt = 1'b1;
      end else begin
        m_we         = 1'b1;
        m_wd         = in_value;
        main_cnt_nxt = main_cnt_r + CW'(1);
      end
    end
    if (cmd.mv_rd || cmd.cmp_rd) begin
      m_re = 1'b1;
    end
    if (cmd.out_rd) begin
      m_re         = 1'b1;
      main_cnt_nxt = main_dec;
    end
    if (cmd.mv_wr || cmd.cmp_mv) begin
      a_we         = 1'b1;
      aux_cnt_nxt  = aux_cnt_r + CW'(1);
      main_cnt_nxt = main_dec;
    end
    if (cmd.ax_rd) begin
      a_re        = 1'b1;
      aux_cnt_nxt = aux_dec;
    end
    if (cmd.push_t) begin
      m_we         = 1'b1;
      main_cnt_nxt = main_cnt_r + CW'(1);
    end
    if (cmd.clear) begin
      main_cnt_nxt = '0;
      aux_cnt_nxt  = '0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_cnt_r  <= '0;
      aux_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      main_cnt_r <= main_cnt_nxt;
      aux_cnt_r  <= aux_cnt_nxt;
      ovf_r      <= ovf_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ax_ld) begin
      t_r <= a_rd;
    end
    if (cmd.out_ld) begin
      out_value_r <= m_rd;
      // count already popped, so empty means this is the final result
      out_last_r  <= (main_cnt_r == '0);
      out_ovf_r   <= ovf_r;
    end
  end

  assign sts.main_empty = (main_cnt_r == '0);
  assign sts.aux_empty  = (aux_cnt_r == '0);
  assign sts.full       = (main_cnt_r == CW'(DEPTH));
  assign sts.gt         = ($signed(t_r) > $signed(m_rd));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

// ----- rtl/two_stack_sorter_unit.sv -----
// Two-stack sorter. Each input request pushes a signed 32-bit value onto a stack
// of DEPTH entries; values beyond DEPTH are dropped and flag overflow on every
// result of that set. A request with in_last set (its value pushed too) starts a
// sort with an auxiliary stack by insertion, after which the set is drained in
// ascending order, one result per stored value, out_last_res on the final one.
// Filling takes one request per cycle. The sort first moves the whole main stack
// onto the aux stack, then pops each aux value as the held value and compares it
// with the main top, moving smaller main values back onto aux until the held value
// can be pushed onto main or main is empty. The drain pops one result whenever the
// output register is free. Each stack is one ram with a single read port and a
// registered read, so every stack access needs a read step and then a use step.
// in_ready is low from the last request of a set until the final result has been
// loaded into the output register and the counts are cleared on the way back to
// filling; the rams need no clearing after reset.
module two_stack_sorter_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tss_pkg::DATA_W-1:0] in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tss_pkg::DATA_W-1:0] out_value_res,
  output logic                       out_last_res,
  output logic                       out_overflow
);

  import tss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tss_dp #(.DEPTH(DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .out_overflow  (out_overflow)
  );

endmodule

// ----- rtl/tss_checker.sv -----
// port-level checks for the two-stack sorter, bound to the top level
module tss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tss_pkg::DATA_W-1:0] out_value_res,
  input logic                       out_last_res,
  input logic                       out_overflow
);

  // a result held back keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res)
      && $stable(out_last_res) && $stable(out_overflow))
    else $error("result changed while stalled");

  // a request that does not close the set leaves the block taking requests
  a_fill_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("in_ready dropped after a non-final request");

  // closing request starts the sort, so no request is taken next cycle
  a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("in_ready high right after the final request");

  // while a non-final result is shown the drain is still running
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_res |-> !in_ready)
    else $error("requests taken before the set is drained");

endmodule

bind two_stack_sorter_unit tss_checker u_tss_checker (.*);

// ----- tb/sv/tb_two_stack_sorter_unit.sv -----
// testbench for the two-stack sorter: directed table then random sets, checked against a predictor
`timescale 1ns / 100ps

module tb_two_stack_sorter_unit;
  import tss_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int          ITEM_TARGET  = 460;
  localparam int          IDLE_LIMIT   = 100000;
  localparam int          HOLD_CYCLES  = 4000;
  localparam int          DRAIN_TAIL   = 40;
  localparam int          DIR_ROWS_N   = 20;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_word_t;

  // typed rows are one-value sets whose single result is written out here
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] exp_value;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hffff_fffd, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{32'hffff_fffe, 1'b0, 1'b0, 32'h0},
    '{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{32'haaaa_aaaa, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0},
    '{32'h0000_002a, 1'b0, 1'b0, 32'h0},
    '{32'h0000_002a, 1'b0, 1'b0, 32'h0},
    '{32'h0000_002a, 1'b1, 1'b0, 32'h0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] in_value;
  logic              in_last;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_value_res;
  logic              out_last_res;
  logic              out_overflow;

  // predictor state: values of the open set kept in ascending order
  logic signed [DATA_W-1:0] stacked_vals[$];
  bit                       dropped_any;
  sorted_word_t             sorted_out_q[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit long_hold   = 1'b0;

  two_stack_sorter_unit #(.DEPTH(DEPTH)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic sort_model_accept(input logic signed [DATA_W-1:0] v, input logic l,
                                   input bit queue_it);
    int pos;
    int n;
    sorted_word_t res;
    if (stacked_vals.size() < DEPTH) begin
      pos = 0;
      while (pos < stacked_vals.size() && stacked_vals[pos] <= v) pos++;
      stacked_vals.insert(pos, v);
    end else begin
      dropped_any = 1'b1;
    end
    if (l) begin
      n = stacked_vals.size();
      if (queue_it) begin
        for (int i = 0; i < n; i++) begin
          res.value = stacked_vals[i];
          res.last  = (i == n - 1);
          res.ovf   = dropped_any;
          sorted_out_q.push_back(res);
        end
      end
      stacked_vals.delete();
      dropped_any = 1'b0;
    end
  endtask

  // one input request; the sender then either carries on or idles for a gap
  task automatic push_request(input logic [DATA_W-1:0] v, input logic l,
                              input logic typed, input logic [DATA_W-1:0] exp_v);
    int gap;
    sorted_word_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    sort_model_accept(v, l, !typed);
    if (typed) begin
      res.value = exp_v;
      res.last  = 1'b1;
      res.ovf   = 1'b0;
      sorted_out_q.push_back(res);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(4, 0) == 0) ? $urandom_range(30, 10) : $urandom_range(4, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? 80 : $urandom_range(16, 0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (sorted_out_q.size() == 0);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(9, 0))
      0, 1: w = $urandom_range(15, 0) - 32'd8;
      2: begin
        case ($urandom_range(3, 0))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7fff_ffff;
          2:       w = '0;
          default: w = '1;
        endcase
      end
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // receiver stall pattern, with one long hold-off on request from the stimulus
  initial begin : rx_stall
    rx_mode_t mode;
    int left;
    int hold_cnt;
    out_ready = 1'b0;
    left = 0;
    mode = RX_OPEN;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk);
          hold_cnt++;
        end
        long_hold = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(3, 0));
        left = $urandom_range(96, 16);
      end
      left--;
      case (mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= ($urandom_range(1, 0) == 1);
        RX_PERIODIC: out_ready <= (left % 4 != 0);
        default:     out_ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    sorted_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_out_q.size() == 0) begin
        $error("unexpected result: value_res %0d", $signed(out_value_res));
        mismatches++;
      end else begin
        want = sorted_out_q.pop_front();
        if (out_value_res !== want.value) begin
          $error("value_res: expected %0d, got %0d", want.value, $signed(out_value_res));
          mismatches++;
        end
        if (out_last_res !== want.last) begin
          $error("last_res: expected %0b, got %0b", want.last, out_last_res);
          mismatches++;
        end
        if (out_overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, out_overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    int set_no;
    int set_size;
    int r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    dropped_any = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      push_request(DIR_ROWS[i].value, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                   DIR_ROWS[i].exp_value);
    end

    // mostly small sets; a few fill the stack exactly or run past it
    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(9, 0);
      if (set_no == 3)
        set_size = 20;
      else if (set_no == 6)
        set_size = DEPTH;
      else if (set_no == 14)
        set_size = DEPTH + 1;
      else if (set_no == 22)
        set_size = DEPTH + 4;
      else if (r < 6)
        set_size = $urandom_range(6, 1);
      else if (r < 9)
        set_size = $urandom_range(16, 7);
      else
        set_size = $urandom_range(32, 17);
      // receiver holds off while the sender keeps offering this set and the next
      if (set_no == 3) long_hold = 1'b1;
      for (int k = 0; k < set_size; k++) begin
        push_request(rand_word(), k == set_size - 1, 1'b0, '0);
      end
      if (set_no == 9) wait_drained();
      set_no++;
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
